// File: hdl/assert_macros.svh
// Assertion helpers for the clip normaliser
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define CLD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CLD_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CLD_ASSERT(label, clk, rst, prop, msg)
`define CLD_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// File: hdl/cld_pkg.sv
`timescale 1ns / 1ps
package cld_pkg;
   localparam int MAX_SAMPLES = 65536;
   localparam int ADDR_W      = $clog2(MAX_SAMPLES);
   localparam int CNT_W       = ADDR_W + 1;
   localparam int CLEN_W      = 17;
   localparam int SAMPLE_W    = 16;
   localparam int VAL_W       = 16;
   localparam int GUARD_BITS  = 8;
   localparam int SUM_W       = SAMPLE_W + CNT_W;
   localparam int MEAN_W      = SAMPLE_W + GUARD_BITS + 1;
   localparam int D_W         = MEAN_W + 1;
   localparam int MAG_W       = MEAN_W;
   localparam int TARGET_Q15  = 31130;
   localparam int GAIN_FRAC   = 40;
   localparam int GAIN_W      = 55;
   localparam int DIV_NUM_W   = GAIN_W + 1;
   localparam int DIV_DEN_W   = MAG_W;
   localparam int DIV_CNT_W   = $clog2(DIV_NUM_W);
   localparam int MUL_B_W     = 28;
   localparam int MUL_P_W     = MAG_W + MUL_B_W;
   localparam int PROD_W      = 64;
   localparam int QMAG_W      = PROD_W - GAIN_FRAC;
   localparam int CLIP_RESET  = 48000;

   typedef enum logic [9:0] {
      ST_IDLE   = 10'b00_0000_0001,
      ST_SUM    = 10'b00_0000_0010,
      ST_MEAN   = 10'b00_0000_0100,
      ST_PEAK   = 10'b00_0000_1000,
      ST_GAIN   = 10'b00_0001_0000,
      ST_READ   = 10'b00_0010_0000,
      ST_CALC   = 10'b00_0100_0000,
      ST_MUL_LO = 10'b00_1000_0000,
      ST_MUL_HI = 10'b01_0000_0000,
      ST_RND    = 10'b10_0000_0000
   } state_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] num;
      logic [DIV_DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_NUM_W-1:0] quo;
   } div_rsp_type;
endpackage

// File: hdl/cld_div.sv
`timescale 1ns / 1ps
module cld_div import cld_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_NUM_W-1:0] num_ff, num_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_DEN_W:0]   trial;

   // restoring divide, one quotient bit per cycle shifted into num_ff
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      trial   = {rem_ff, num_ff[DIV_NUM_W-1]};
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         num_in  = req.num;
         rem_in  = '0;
         den_in  = req.den;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = DIV_DEN_W'(trial - {1'b0, den_ff});
            num_in = {num_ff[DIV_NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DIV_DEN_W-1:0];
            num_in = {num_ff[DIV_NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quo  = num_ff;
endmodule

// File: hdl/clip_dc_removal_peak_normalize_top.sv
`timescale 1ns / 1ps
// Channel  Direction  Handshake             Payload
// req      in         req_tvalid/tready     tuser: mode; tdata: sample
// rsp      out        rsp_tvalid/tready     tdata: value; tlast: last
// csr      in         csr_valid/csr_ready   csr_data: clip_length
// A push is one store write. The first pull of a clip runs the fix
// sequence: optional re-sum, mean divide, peak walk, and a gain divide
// unless the peak is zero, all on one memory port and one shared divider.
// Each pull then reads, centres, multiplies (low then high half, skipped
// for zero gain) and rounds. Reset is synchronous; the store holds no reset.
// A held result stalls the next pull at rounding, and no push is taken meanwhile.
`include "assert_macros.svh"
module clip_dc_removal_peak_normalize_top import cld_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [15:0]         req_tdata,   // [15:0] sample
   input  logic                req_tuser,   // [0] mode
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [15:0]         rsp_tdata,   // [15:0] value
   output logic                rsp_tlast,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CLEN_W-1:0]   csr_data
);
   state_type                  state_ff, state_in;
   logic [CLEN_W-1:0]          clip_len_ff, clip_len_in;
   logic [CNT_W-1:0]           stored_cnt_ff, stored_cnt_in;
   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic signed [MEAN_W-1:0]   mean_ff, mean_in;
   logic [GAIN_W-1:0]          gain_ff, gain_in;
   logic [CNT_W-1:0]           read_idx_ff, read_idx_in;
   logic                       emitting_ff, emitting_in;
   logic [CNT_W-1:0]           iss_ff, iss_in;
   logic                       pend_ff, pend_in;
   logic                       pad_ff, pad_in;
   logic [MAG_W-1:0]           peak_ff, peak_in;
   logic [MAG_W-1:0]           mag_ff, mag_in;
   logic                       neg_ff, neg_in;
   logic [MUL_P_W-1:0]         acc_ff, acc_in;
   logic [MUL_P_W-1:0]         mul_p_ff, mul_p_in;
   logic [VAL_W-1:0]           val_ff, val_in;
   logic                       last_ff, last_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0]           rsp_data_ff, rsp_data_in;
   logic                       rsp_last_ff, rsp_last_in;

   logic [SAMPLE_W-1:0]        mem [MAX_SAMPLES];
   logic [SAMPLE_W-1:0]        rd_data_ff;
   logic [ADDR_W-1:0]          rd_addr;
   logic                       mem_we;

   logic [CNT_W-1:0]           eff_len;
   logic signed [SAMPLE_W-1:0] smp;
   logic signed [D_W-1:0]      cd;
   logic                       cneg;
   logic [MAG_W-1:0]           cmag;
   logic [SUM_W-1:0]           sum_mag;
   logic [MEAN_W-1:0]          mq;
   logic [MUL_B_W-1:0]         mul_b;
   logic [PROD_W-1:0]          prod;
   logic [QMAG_W-1:0]          qmag;
   logic [CNT_W:0]             next_idx;
   div_req_type                div_req;
   div_rsp_type                div_rsp;
   logic                       push_ok;

   cld_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   always_comb begin
      if (clip_len_ff == '0) begin
         eff_len = CNT_W'(1);
      end else if (clip_len_ff > CLEN_W'(MAX_SAMPLES)) begin
         eff_len = CNT_W'(MAX_SAMPLES);
      end else begin
         eff_len = CNT_W'(clip_len_ff);
      end
   end

   // centred magnitude of the word just read
   assign smp     = pad_ff ? '0 : rd_data_ff;
   assign cd      = (D_W'(smp) <<< GUARD_BITS) - D_W'(mean_ff);
   assign cneg    = cd[D_W-1];
   assign cmag    = MAG_W'(cneg ? -cd : cd);
   assign sum_mag = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
   assign mq      = MEAN_W'(div_rsp.quo[MEAN_W-2:0]);
   assign mul_b   = (state_ff == ST_MUL_LO) ? gain_ff[MUL_B_W-1:0]
                                            : MUL_B_W'(gain_ff[GAIN_W-1:MUL_B_W]);
   assign prod    = PROD_W'(acc_ff) + (PROD_W'(mul_p_ff) << MUL_B_W)
                    + (PROD_W'(1) << (GAIN_FRAC - 1));
   assign next_idx = {1'b0, read_idx_ff} + 1'b1;
   assign push_ok  = !emitting_ff && (stored_cnt_ff < eff_len);
   assign rd_addr  = (state_ff == ST_READ) ? read_idx_ff[ADDR_W-1:0] : iss_ff[ADDR_W-1:0];
   assign mem_we   = req_tvalid && req_tready && !req_tuser && push_ok;

   always_comb begin
      div_req.start = 1'b0;
      if (state_ff == ST_PEAK) begin
         div_req.num = (DIV_NUM_W'(TARGET_Q15) << GAIN_FRAC) + DIV_NUM_W'(peak_ff >> 1);
         div_req.den = peak_ff;
      end else begin
         div_req.num = DIV_NUM_W'({sum_mag, GUARD_BITS'(0)}) + DIV_NUM_W'(eff_len >> 1);
         div_req.den = DIV_DEN_W'(eff_len);
      end

      state_in      = state_ff;
      clip_len_in   = clip_len_ff;
      stored_cnt_in = stored_cnt_ff;
      sum_in        = sum_ff;
      mean_in       = mean_ff;
      gain_in       = gain_ff;
      read_idx_in   = read_idx_ff;
      emitting_in   = emitting_ff;
      iss_in        = iss_ff;
      pend_in       = 1'b0;
      pad_in        = pad_ff;
      peak_in       = peak_ff;
      mag_in        = mag_ff;
      neg_in        = neg_ff;
      acc_in        = acc_ff;
      mul_p_in      = MUL_P_W'(mag_ff) * MUL_P_W'(mul_b);
      val_in        = val_ff;
      last_in       = last_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;
      qmag          = '0;

      if (csr_valid) begin
         clip_len_in = csr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (!req_tuser) begin
                  if (push_ok) begin
                     stored_cnt_in = stored_cnt_ff + 1'b1;
                     sum_in = sum_ff + SUM_W'(signed'(req_tdata));
                  end
               end else if (emitting_ff) begin
                  state_in = ST_READ;
               end else if (stored_cnt_ff > eff_len) begin
                  sum_in   = '0;
                  iss_in   = '0;
                  state_in = ST_SUM;
               end else begin
                  div_req.start = 1'b1;
                  state_in      = ST_MEAN;
               end
            end
         end
         ST_SUM: begin
            if (iss_ff < eff_len) begin
               iss_in  = iss_ff + 1'b1;
               pend_in = 1'b1;
            end
            if (pend_ff) begin
               sum_in = sum_ff + SUM_W'(signed'(rd_data_ff));
            end else if (iss_ff >= eff_len) begin
               stored_cnt_in = eff_len;
               div_req.start = 1'b1;
               state_in      = ST_MEAN;
            end
         end
         ST_MEAN: begin
            if (div_rsp.done) begin
               mean_in  = sum_ff[SUM_W-1] ? -mq : mq;
               iss_in   = '0;
               peak_in  = '0;
               state_in = ST_PEAK;
            end
         end
         ST_PEAK: begin
            if (iss_ff < eff_len) begin
               iss_in  = iss_ff + 1'b1;
               pend_in = 1'b1;
               pad_in  = iss_ff >= stored_cnt_ff;
            end
            if (pend_ff) begin
               if (cmag > peak_ff) begin
                  peak_in = cmag;
               end
            end else if (iss_ff >= eff_len) begin
               read_idx_in = '0;
               emitting_in = 1'b1;
               if (peak_ff == '0) begin
                  gain_in  = '0;
                  state_in = ST_READ;
               end else begin
                  div_req.start = 1'b1;
                  state_in      = ST_GAIN;
               end
            end
         end
         ST_GAIN: begin
            if (div_rsp.done) begin
               gain_in  = div_rsp.quo[GAIN_W-1:0];
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            pad_in   = read_idx_ff >= stored_cnt_ff;
            state_in = ST_CALC;
         end
         ST_CALC: begin
            mag_in   = cmag;
            neg_in   = cneg;
            state_in = (gain_ff == '0) ? ST_RND : ST_MUL_LO;
         end
         ST_MUL_LO: begin
            state_in = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            acc_in   = mul_p_ff;
            state_in = ST_RND;
         end
         ST_RND: begin
            if (gain_ff == '0) begin
               qmag = QMAG_W'(({1'b0, mag_ff} + (MAG_W'(1) << (GUARD_BITS - 1))) >> GUARD_BITS);
            end else begin
               qmag = prod[PROD_W-1:GAIN_FRAC];
            end
            if (!neg_ff) begin
               val_in = (qmag > QMAG_W'(32767)) ? VAL_W'(32767) : qmag[VAL_W-1:0];
            end else begin
               val_in = (qmag >= QMAG_W'(32768)) ? VAL_W'(32768)
                                                 : VAL_W'(VAL_W'(0) - qmag[VAL_W-1:0]);
            end
            last_in = next_idx >= {1'b0, eff_len};
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = val_in;
               rsp_last_in  = last_in;
               if (last_in) begin
                  stored_cnt_in = '0;
                  sum_in        = '0;
                  read_idx_in   = '0;
                  emitting_in   = 1'b0;
               end else begin
                  read_idx_in = next_idx[CNT_W-1:0];
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         clip_len_ff   <= CLEN_W'(CLIP_RESET);
         stored_cnt_ff <= '0;
         sum_ff        <= '0;
         mean_ff       <= '0;
         gain_ff       <= '0;
         read_idx_ff   <= '0;
         emitting_ff   <= 1'b0;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clip_len_ff   <= clip_len_in;
         stored_cnt_ff <= stored_cnt_in;
         sum_ff        <= sum_in;
         mean_ff       <= mean_in;
         gain_ff       <= gain_in;
         read_idx_ff   <= read_idx_in;
         emitting_ff   <= emitting_in;
         pend_ff       <= pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      iss_ff      <= iss_in;
      pad_ff      <= pad_in;
      peak_ff     <= peak_in;
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      acc_ff      <= acc_in;
      mul_p_ff    <= mul_p_in;
      val_ff      <= val_in;
      last_ff     <= last_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[stored_cnt_ff[ADDR_W-1:0]] <= req_tdata;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   `CLD_ASSERT(a_cnt_bound, clock, reset, stored_cnt_ff <= CNT_W'(MAX_SAMPLES), "store count overrun")
   `CLD_ASSERT(a_idx_bound, clock, reset, emitting_ff |-> read_idx_ff < CNT_W'(MAX_SAMPLES), "read index overrun")
   `CLD_ASSERT(a_div_busy, clock, reset, div_req.start |=> !req_tready, "transaction taken during divide")
   `CLD_ASSERT(a_rsp_src, clock, reset, $rose(rsp_tvalid) |-> $past(state_ff == ST_RND), "result from wrong state")
endmodule

// File: verif/clip_dc_removal_peak_normalize_top_tb.sv
`timescale 1ns / 1ps
module clip_dc_removal_peak_normalize_top_tb;
   import cld_pkg::*;

   localparam int LULL_LIMIT = 400000;

   typedef struct {
      logic        mode;
      logic [15:0] sample;
   } pcm_req_t;

   typedef struct {
      logic [15:0] value;
      logic        last;
   } norm_out_t;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [15:0]       req_tdata = '0;
   logic              req_tuser = 1'b0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [15:0]       rsp_tdata;
   logic              rsp_tlast;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [CLEN_W-1:0] csr_data = '0;

   clip_dc_removal_peak_normalize_top dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   pcm_req_t  feed_q[$];
   norm_out_t norm_q[$];
   int        errors = 0;
   int        gap_max = 6;
   int        stall_max = 5;

   // predictor state
   logic signed [15:0] clip_mem [MAX_SAMPLES];
   int                 fill_cnt = 0;
   longint             pcm_sum = 0;
   longint             dc_level = 0;
   longint unsigned    scale = 0;
   int                 rd_pos = 0;
   bit                 draining = 0;
   logic [CLEN_W-1:0]  len_reg = CLEN_W'(CLIP_RESET);

   function automatic int active_len();
      if (len_reg == 0) return 1;
      if (len_reg > MAX_SAMPLES) return MAX_SAMPLES;
      return int'(len_reg);
   endfunction

   function automatic longint div_round(longint num, longint den);
      longint mag;
      longint q;
      mag = (num < 0) ? -num : num;
      q = (mag + den / 2) / den;
      return (num < 0) ? -q : q;
   endfunction

   function automatic longint centred(int i);
      longint s;
      s = (i < fill_cnt) ? longint'(clip_mem[i]) : 0;
      return s * (64'sd1 <<< GUARD_BITS) - dc_level;
   endfunction

   function automatic void settle_clip();
      int              len;
      longint          d;
      longint unsigned pk;
      longint unsigned m;
      len = active_len();
      pk = 0;
      if (fill_cnt > len) begin
         pcm_sum = 0;
         for (int i = 0; i < len; i++) pcm_sum += clip_mem[i];
         fill_cnt = len;
      end
      dc_level = div_round(pcm_sum * (64'sd1 <<< GUARD_BITS), len);
      for (int i = 0; i < len; i++) begin
         d = centred(i);
         m = (d < 0) ? -d : d;
         if (m > pk) pk = m;
      end
      if (pk == 0) scale = 0;
      else scale = ((64'(TARGET_Q15) << GAIN_FRAC) + pk / 2) / pk;
      rd_pos = 0;
      draining = 1;
   endfunction

   function automatic void predict(pcm_req_t it);
      longint          d;
      longint          v;
      longint unsigned m;
      longint unsigned q;
      norm_out_t       o;
      if (it.mode == 1'b0) begin
         if (!draining && fill_cnt < active_len()) begin
            clip_mem[fill_cnt] = it.sample;
            fill_cnt++;
            pcm_sum += longint'($signed(it.sample));
         end
         return;
      end
      if (!draining) settle_clip();
      d = centred(rd_pos);
      if (scale == 0) begin
         v = div_round(d, 64'sd1 <<< GUARD_BITS);
      end else begin
         m = (d < 0) ? -d : d;
         q = (m * scale + (64'd1 << (GAIN_FRAC - 1))) >> GAIN_FRAC;
         v = (d < 0) ? -longint'(q) : longint'(q);
      end
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      o.value = v[15:0];
      o.last = (rd_pos + 1 >= active_len());
      norm_q.push_back(o);
      if (o.last) begin
         fill_cnt = 0;
         pcm_sum = 0;
         rd_pos = 0;
         draining = 0;
      end else begin
         rd_pos++;
      end
   endfunction

   // driver
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (feed_q.size() > 0) begin
            pcm_req_t it;
            it = feed_q.pop_front();
            req_tvalid <= 1'b1;
            req_tuser <= it.mode;
            req_tdata <= it.sample;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 40);
               gap_left = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver stall pattern
   int run_left = 0;
   int stall_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (run_left > 0) begin
            run_left--;
         end else begin
            run_left = $urandom_range(0, 30);
            stall_left = (stall_max == 0) ? 0 : $urandom_range(0, stall_max);
         end
      end
   end

   // monitors
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         pcm_req_t it;
         it.mode = req_tuser;
         it.sample = req_tdata;
         predict(it);
      end
      if (!reset && csr_valid && csr_ready) len_reg <= csr_data;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         norm_out_t e;
         if (norm_q.size() == 0) begin
            $display("%0t: unexpected transaction value=%h last=%b",
                     $time, rsp_tdata, rsp_tlast);
            errors++;
         end else begin
            e = norm_q.pop_front();
            if (rsp_tdata !== e.value) begin
               $display("%0t: value expected %h actual %h", $time, e.value, rsp_tdata);
               errors++;
            end
            if (rsp_tlast !== e.last) begin
               $display("%0t: last expected %b actual %b", $time, e.last, rsp_tlast);
               errors++;
            end
         end
      end
   end

   // watchdog
   int lull = 0;
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         lull <= 0;
      end else if (lull >= LULL_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         lull <= lull + 1;
      end
   end

   task automatic push(logic [15:0] s);
      pcm_req_t it;
      it.mode = 1'b0;
      it.sample = s;
      feed_q.push_back(it);
   endtask

   task automatic pull(int n);
      pcm_req_t it;
      for (int i = 0; i < n; i++) begin
         it.mode = 1'b1;
         it.sample = 16'($urandom);
         feed_q.push_back(it);
      end
   endtask

   task automatic settle();
      while (feed_q.size() > 0 || req_tvalid || norm_q.size() > 0) @(negedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_len(int v);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= CLEN_W'(v);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [15:0] rand_pcm();
      case ($urandom_range(0, 3))
         0: return 16'($urandom_range(0, 6) - 3);
         1: return 16'($urandom_range(0, 600) - 300);
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      int total;
      int len;
      int cnt;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // full-scale extremes, overfill, pushes ignored between pulls
      write_len(4);
      push(16'h7FFF); push(16'h8000); push(16'h0000); push(16'hFFFF); push(16'h0005);
      pull(2); push(16'h1234); pull(2);
      settle();
      // zero length behaves as one; silent clip
      write_len(0);
      push(16'h0000); pull(1); push(16'h0000); pull(1);
      settle();
      // empty clip padded, constant clip
      write_len(3);
      pull(3); push(16'd100); push(16'd100); push(16'd100); pull(3);
      settle();
      // length lowered before the first pull
      write_len(5);
      push(16'h4000); push(16'hC000); push(16'h0010); push(16'h7000); push(16'h8001);
      settle();
      write_len(2);
      pull(2);
      settle();
      // length changed mid-readout, raised then lowered
      write_len(4);
      push(16'd1000); push(16'd2000); push(16'd3000); push(16'd4000); pull(2);
      settle();
      write_len(6);
      pull(4);
      settle();
      write_len(5);
      push(16'h0AAA); push(16'hF555); push(16'h7FFF); push(16'h8000); push(16'h0001); pull(3);
      settle();
      write_len(2);
      pull(1);
      settle();

      // oversize length, the full store, closed early by a shorter length
      write_len(131071);
      gap_max = 0;
      stall_max = 0;
      for (int i = 0; i < 24; i++) push(rand_pcm());
      pull(3);
      settle();
      write_len(1);
      pull(1);
      settle();
      write_len(MAX_SAMPLES);
      gap_max = 6;
      stall_max = 5;

      total = 0;
      while (total < 1500) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 300) : $urandom_range(1, 40);
         write_len(len);
         cnt = $urandom_range(0, len + 3);
         for (int i = 0; i < cnt; i++) push(rand_pcm());
         if ($urandom_range(0, 7) == 0) begin
            pull($urandom_range(1, len));
            settle();
            len = $urandom_range(0, 50);
            write_len(len);
         end
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 9) == 0) push(16'($urandom));
            pull(1);
         end
         // close the clip in case the length change left it open
         pull(1);
         total += cnt + len + 1;
         settle();
         if (draining) begin
            write_len(1);
            pull(1);
            settle();
         end
      end

      settle();
      if (errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule

// File: files.f
+incdir+hdl
hdl/cld_pkg.sv
hdl/cld_div.sv
hdl/clip_dc_removal_peak_normalize_top.sv
verif/clip_dc_removal_peak_normalize_top_tb.sv
